[rtl/tss_pkg.sv]
package tss_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LOW  = 2'd0,
      OP_POP_LOW   = 2'd1,
      OP_PUSH_HIGH = 2'd2,
      OP_POP_HIGH  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PEND = 2'b10
   } state_type;

   typedef struct packed {
      logic accept;
      logic advance;
   } cmd_type;

endpackage

[rtl/tss_if.sv]
interface tss_req_if import tss_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

interface tss_rsp_if import tss_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output popped_value, output status, input ready);
   modport sink (input valid, input popped_value, input status, output ready);
endinterface

[rtl/tss_ram.sv]
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tss_ctrl.sv]
module tss_ctrl import tss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      advance;
   logic      accept;

   assign advance   = (state_ff == ST_PEND) && (!out_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (accept) begin
               state_in = ST_PEND;
            end else if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign cmd.accept  = accept;
   assign cmd.advance = advance;

endmodule

[rtl/tss_dp.sv]
module tss_dp import tss_pkg::*; #(
   parameter int STORE_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [OP_W-1:0]          operation,
   input  logic signed [DATA_W-1:0] value,
   output logic signed [DATA_W-1:0] popped_value,
   output logic [STATUS_W-1:0]      status
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW:0] DEPTH_SUM = (CW+1)'(STORE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(STORE_DEPTH);

   logic [CW-1:0]     count_low_ff, count_low_in;
   logic [CW-1:0]     count_high_ff, count_high_in;
   status_type        pend_status_ff, pend_status_in;
   logic              pend_pop_ff, pend_pop_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   status_type        out_status_ff, out_status_in;

   logic              full;
   logic              wr_en;
   logic              rd_en;
   logic [CW-1:0]     addr_wide;
   logic [DATA_W-1:0] rd_data;
   op_type            op;

   assign op   = op_type'(operation);
   assign full = ({1'b0, count_low_ff} + {1'b0, count_high_ff}) >= DEPTH_SUM;

   always_comb begin
      count_low_in   = count_low_ff;
      count_high_in  = count_high_ff;
      pend_status_in = pend_status_ff;
      pend_pop_in    = pend_pop_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      addr_wide      = count_low_ff;
      if (cmd.accept) begin
         pend_status_in = STATUS_DONE;
         pend_pop_in    = 1'b0;
         case (op)
            OP_PUSH_LOW: begin
               addr_wide = count_low_ff;
               if (full) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  wr_en        = 1'b1;
                  count_low_in = count_low_ff + 1'b1;
               end
            end
            OP_POP_LOW: begin
               addr_wide = count_low_ff - 1'b1;
               if (count_low_ff == '0) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  pend_pop_in  = 1'b1;
                  count_low_in = count_low_ff - 1'b1;
               end
            end
            OP_PUSH_HIGH: begin
               addr_wide = DEPTH_CNT - 1'b1 - count_high_ff;
               if (full) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  wr_en         = 1'b1;
                  count_high_in = count_high_ff + 1'b1;
               end
            end
            OP_POP_HIGH: begin
               addr_wide = DEPTH_CNT - count_high_ff;
               if (count_high_ff == '0) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  rd_en         = 1'b1;
                  pend_pop_in   = 1'b1;
                  count_high_in = count_high_ff - 1'b1;
               end
            end
            default: begin
               pend_status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_comb begin
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (cmd.advance) begin
         out_value_in  = pend_pop_ff ? rd_data : '0;
         out_status_in = pend_status_ff;
      end
   end

   tss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (addr_wide[AW-1:0]),
      .wr_data (value),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_low_ff  <= '0;
         count_high_ff <= '0;
      end else begin
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_pop_ff    <= pend_pop_in;
      out_value_ff   <= out_value_in;
      out_status_ff  <= out_status_in;
   end

   assign popped_value = out_value_ff;
   assign status       = out_status_ff;

endmodule

[rtl/two_stacks_shared_store.sv]
// Two stacks in one store of STORE_DEPTH 32-bit words: stack one grows up from word 0,
// stack two grows down from the last word. Each request word (push or pop on either stack)
// gives exactly one response word with a status of done, full or empty; a successful pop
// returns the removed word, anything else returns zero. The store is written or read at the
// edge that accepts the request; the word and status then wait in a pending stage, and the
// response register loads when that stage advances, which waits while an earlier response
// word is not yet taken. A request can be accepted every cycle while the response side
// keeps taking words. While a response word waits, one more request is taken and held,
// then the request side stalls until the response is taken. No clearing pass is needed
// after reset: only the two fill counts, control state and valid flag are cleared.
module two_stacks_shared_store import tss_pkg::*; #(
   parameter int STORE_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   tss_req_if.sink    req_ch,
   tss_rsp_if.source  rsp_ch
);

   cmd_type cmd;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tss_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .operation    (req_ch.operation),
      .value        (req_ch.value),
      .popped_value (rsp_ch.popped_value),
      .status       (rsp_ch.status)
   );

endmodule
